### rtl/ir_pulse_width_frame_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// IR pulse width frame decoder assertion macros
// Concurrent check wrappers on clk, with and without the synchronous reset.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_WIDTH_FRAME_DECODER_TOP_DEFINES_SVH
`define IR_PULSE_WIDTH_FRAME_DECODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define IRPWFD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define IRPWFD_ASSERT_ANY(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define IRPWFD_ASSERT(name, prop, msg)
`define IRPWFD_ASSERT_ANY(name, prop, msg)
`endif

`endif

### rtl/irpwfd_pkg.sv
// ----------------------------------------------------------------------------
// IR pulse width frame decoder package
// Register codes, reset values, state encodings and window compare helpers.
// ----------------------------------------------------------------------------
package irpwfd_pkg;

  localparam int DUR_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int IDX_OUT_W = 5;

  typedef logic [DUR_W-1:0] dur_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEADER_MARK  = 3'd0,
    REG_LEADER_SPACE = 3'd1,
    REG_BIT_MARK     = 3'd2,
    REG_ZERO_SPACE   = 3'd3,
    REG_ONE_SPACE    = 3'd4,
    REG_STOP_SPACE   = 3'd5,
    REG_TOLERANCE    = 3'd6
  } cfg_reg_t;

  localparam dur_t RST_LEADER_MARK  = 16'd4400;
  localparam dur_t RST_LEADER_SPACE = 16'd4400;
  localparam dur_t RST_BIT_MARK     = 16'd540;
  localparam dur_t RST_ZERO_SPACE   = 16'd540;
  localparam dur_t RST_ONE_SPACE    = 16'd1620;
  localparam dur_t RST_STOP_SPACE   = 16'd5220;
  localparam dur_t RST_TOLERANCE    = 16'd200;

  localparam logic [7:0] MASK_MSB = 8'h80;

  typedef enum logic [3:0] {
    PH_LEADER = 4'b0001,
    PH_DATA   = 4'b0010,
    PH_STOP   = 4'b0100,
    PH_FAIL   = 4'b1000
  } phase_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_APPLY = 6'b000100,
    ST_READ  = 6'b001000,
    ST_LOAD  = 6'b010000,
    ST_SHOW  = 6'b100000
  } ctrl_t;

  typedef struct packed {
    logic mark_lead;
    logic mark_bit;
    logic space_lead;
    logic space_zero;
    logic space_one;
    logic stop_lo_ok;
    logic stop_hi_ok;
  } match_t;

  function automatic dur_t win_lo(input dur_t nom, input dur_t tol);
    return (nom > tol) ? dur_t'(nom - tol) : '0;
  endfunction

  function automatic logic below_hi(input dur_t nom, input dur_t tol, input dur_t d);
    logic [DUR_W:0] hi;
    hi = {1'b0, nom} + {1'b0, tol};
    return {1'b0, d} <= hi;
  endfunction

  function automatic logic in_win(input dur_t nom, input dur_t tol, input dur_t d);
    return (d >= win_lo(nom, tol)) && below_hi(nom, tol, d);
  endfunction

endpackage

### rtl/ir_pulse_width_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// IR pulse width frame decoder
// Classifies mark/space pairs into leader, data bits and stop, buffers the
// frame bytes in a local memory and plays the frame out once it ends.
// ----------------------------------------------------------------------------
// Requests: a request is taken in idle, then compared and applied (take,
// compare, update); item_stall stays high until the decoder is back in idle,
// so a new request is not taken before the last one is retired.
// Frame play-out: starts once the final stop request retires; each byte is
// read from memory, loaded and handed off, waiting out any output stall.
// Reset: synchronous; control and config registers return to their defaults
// and the decoder waits for a leader; frame memory is not cleared, needs no sweep.
`include "ir_pulse_width_frame_decoder_top_defines.svh"

module ir_pulse_width_frame_decoder_top #(
  parameter int BLOCK_BYTES = 6,
  parameter int FRAME_BYTES = 18
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [irpwfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  irpwfd_pkg::dur_t                    cfg_data,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                func,
  input  irpwfd_pkg::dur_t                    mark_us,
  input  irpwfd_pkg::dur_t                    space_us,
  output logic                                byte_valid,
  input  logic                                byte_stall,
  output logic [7:0]                          data_byte,
  output logic [irpwfd_pkg::IDX_OUT_W-1:0]    byte_index,
  output logic                                last
);

  localparam int CW         = $clog2(FRAME_BYTES + 1);
  localparam int AW         = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int ONE_BLOCK  = BLOCK_BYTES;
  localparam int TWO_BLOCK  = 2 * BLOCK_BYTES;
  localparam int TRI_BLOCK  = 3 * BLOCK_BYTES;

  irpwfd_pkg::dur_t leader_mark_us;
  irpwfd_pkg::dur_t leader_space_us;
  irpwfd_pkg::dur_t bit_mark_us;
  irpwfd_pkg::dur_t zero_space_us;
  irpwfd_pkg::dur_t one_space_us;
  irpwfd_pkg::dur_t stop_space_us;
  irpwfd_pkg::dur_t tolerance_us;

  irpwfd_pkg::ctrl_t  ctrl;
  irpwfd_pkg::phase_t phase;
  irpwfd_pkg::phase_t phase_next;
  irpwfd_pkg::match_t match;
  irpwfd_pkg::match_t match_next;

  logic             item_func;
  irpwfd_pkg::dur_t item_mark;
  irpwfd_pkg::dur_t item_space;

  logic [7:0]    bit_mask;
  logic [7:0]    bit_mask_next;
  logic [7:0]    shift_byte;
  logic [7:0]    shift_byte_next;
  logic [CW-1:0] byte_count;
  logic [CW-1:0] byte_count_next;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_inc;
  logic [7:0]    shift_bit;
  logic [7:0]    mask_shift;
  logic          store_byte;
  logic          emit;
  logic          mem_we;

  logic [7:0] frame_store [FRAME_BYTES];
  logic [7:0] rd_data;

  assign item_stall = (ctrl != irpwfd_pkg::ST_IDLE);
  assign count_inc  = CW'(byte_count + 1'b1);
  assign idx_inc    = CW'(idx + 1'b1);
  assign mem_we     = (ctrl == irpwfd_pkg::ST_APPLY) && store_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      leader_mark_us  <= irpwfd_pkg::RST_LEADER_MARK;
      leader_space_us <= irpwfd_pkg::RST_LEADER_SPACE;
      bit_mark_us     <= irpwfd_pkg::RST_BIT_MARK;
      zero_space_us   <= irpwfd_pkg::RST_ZERO_SPACE;
      one_space_us    <= irpwfd_pkg::RST_ONE_SPACE;
      stop_space_us   <= irpwfd_pkg::RST_STOP_SPACE;
      tolerance_us    <= irpwfd_pkg::RST_TOLERANCE;
    end else if (cfg_write) begin
      unique case (irpwfd_pkg::cfg_reg_t'(cfg_index))
        irpwfd_pkg::REG_LEADER_MARK:  leader_mark_us  <= cfg_data;
        irpwfd_pkg::REG_LEADER_SPACE: leader_space_us <= cfg_data;
        irpwfd_pkg::REG_BIT_MARK:     bit_mark_us     <= cfg_data;
        irpwfd_pkg::REG_ZERO_SPACE:   zero_space_us   <= cfg_data;
        irpwfd_pkg::REG_ONE_SPACE:    one_space_us    <= cfg_data;
        irpwfd_pkg::REG_STOP_SPACE:   stop_space_us   <= cfg_data;
        irpwfd_pkg::REG_TOLERANCE:    tolerance_us    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    match_next.mark_lead  = irpwfd_pkg::in_win(leader_mark_us, tolerance_us, item_mark);
    match_next.mark_bit   = irpwfd_pkg::in_win(bit_mark_us, tolerance_us, item_mark);
    match_next.space_lead = irpwfd_pkg::in_win(leader_space_us, tolerance_us, item_space);
    match_next.space_zero = irpwfd_pkg::in_win(zero_space_us, tolerance_us, item_space);
    match_next.space_one  = irpwfd_pkg::in_win(one_space_us, tolerance_us, item_space);
    match_next.stop_lo_ok = item_space >= irpwfd_pkg::win_lo(stop_space_us, tolerance_us);
    match_next.stop_hi_ok = irpwfd_pkg::below_hi(stop_space_us, tolerance_us, item_space);
  end

  always_comb begin
    phase_next      = phase;
    bit_mask_next   = bit_mask;
    shift_byte_next = shift_byte;
    byte_count_next = byte_count;
    store_byte      = 1'b0;
    emit            = 1'b0;
    shift_bit       = match.space_zero ? shift_byte : (shift_byte | bit_mask);
    mask_shift      = bit_mask >> 1;
    if (item_func) begin
      phase_next      = irpwfd_pkg::PH_LEADER;
      bit_mask_next   = irpwfd_pkg::MASK_MSB;
      shift_byte_next = '0;
      byte_count_next = '0;
    end else begin
      unique case (phase)
        irpwfd_pkg::PH_LEADER: begin
          phase_next = (match.mark_lead && match.space_lead) ?
                       irpwfd_pkg::PH_DATA : irpwfd_pkg::PH_FAIL;
        end
        irpwfd_pkg::PH_DATA: begin
          phase_next = irpwfd_pkg::PH_FAIL;
          if (match.mark_bit && (match.space_zero || match.space_one)) begin
            phase_next = irpwfd_pkg::PH_DATA;
            if (mask_shift == '0) begin
              store_byte      = 1'b1;
              byte_count_next = count_inc;
              shift_byte_next = '0;
              bit_mask_next   = irpwfd_pkg::MASK_MSB;
              if (32'(count_inc) == ONE_BLOCK || 32'(count_inc) == TWO_BLOCK ||
                  32'(count_inc) >= FRAME_BYTES) begin
                phase_next = irpwfd_pkg::PH_STOP;
              end
            end else begin
              shift_byte_next = shift_bit;
              bit_mask_next   = mask_shift;
            end
          end
        end
        irpwfd_pkg::PH_STOP: begin
          phase_next = irpwfd_pkg::PH_FAIL;
          if (match.mark_bit && match.stop_lo_ok) begin
            if (match.stop_hi_ok) begin
              if (32'(byte_count) == ONE_BLOCK || 32'(byte_count) == TWO_BLOCK) begin
                phase_next = irpwfd_pkg::PH_LEADER;
              end
            end else if (32'(byte_count) == TWO_BLOCK || 32'(byte_count) == TRI_BLOCK) begin
              phase_next = irpwfd_pkg::PH_STOP;
              emit       = 1'b1;
            end
          end
        end
        irpwfd_pkg::PH_FAIL: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[byte_count[AW-1:0]] <= shift_bit;
    end
    rd_data <= frame_store[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl       <= irpwfd_pkg::ST_IDLE;
      phase      <= irpwfd_pkg::PH_LEADER;
      bit_mask   <= irpwfd_pkg::MASK_MSB;
      shift_byte <= '0;
      byte_count <= '0;
      idx        <= '0;
      byte_valid <= 1'b0;
    end else begin
      unique case (ctrl)
        irpwfd_pkg::ST_IDLE: begin
          if (item_valid) begin
            item_func  <= func;
            item_mark  <= mark_us;
            item_space <= space_us;
            ctrl       <= irpwfd_pkg::ST_CHECK;
          end
        end
        irpwfd_pkg::ST_CHECK: begin
          match <= match_next;
          ctrl  <= irpwfd_pkg::ST_APPLY;
        end
        irpwfd_pkg::ST_APPLY: begin
          phase      <= phase_next;
          bit_mask   <= bit_mask_next;
          shift_byte <= shift_byte_next;
          byte_count <= byte_count_next;
          if (emit) begin
            idx  <= '0;
            ctrl <= irpwfd_pkg::ST_READ;
          end else begin
            ctrl <= irpwfd_pkg::ST_IDLE;
          end
        end
        irpwfd_pkg::ST_READ: begin
          ctrl <= irpwfd_pkg::ST_LOAD;
        end
        irpwfd_pkg::ST_LOAD: begin
          data_byte  <= rd_data;
          byte_index <= irpwfd_pkg::IDX_OUT_W'(idx);
          last       <= (idx_inc == byte_count);
          byte_valid <= 1'b1;
          ctrl       <= irpwfd_pkg::ST_SHOW;
        end
        irpwfd_pkg::ST_SHOW: begin
          if (!byte_stall) begin
            byte_valid <= 1'b0;
            if (last) begin
              phase      <= irpwfd_pkg::PH_LEADER;
              bit_mask   <= irpwfd_pkg::MASK_MSB;
              shift_byte <= '0;
              byte_count <= '0;
              ctrl       <= irpwfd_pkg::ST_IDLE;
            end else begin
              idx  <= idx_inc;
              ctrl <= irpwfd_pkg::ST_READ;
            end
          end
        end
        default: ctrl <= irpwfd_pkg::ST_IDLE;
      endcase
    end
  end

  `IRPWFD_ASSERT(a_no_take_while_out, byte_valid |-> item_stall, "request taken in play-out")
  `IRPWFD_ASSERT(a_store_in_data, mem_we |-> phase == irpwfd_pkg::PH_DATA, "store outside data")
  `IRPWFD_ASSERT(a_count_bound, 32'(byte_count) <= FRAME_BYTES, "byte count beyond frame")
  `IRPWFD_ASSERT(a_idx_bound, ctrl == irpwfd_pkg::ST_SHOW |-> idx < byte_count, "index past count")
  `IRPWFD_ASSERT_ANY(a_reset_quiet, rst |=> !byte_valid, "output valid after reset")

endmodule
